### design/ftvp_pkg.sv
// ftvp_pkg: shared types and constants of the FIX tag=value parser.
// Holds the result record, configuration record, message state and codes.
// No dependencies.
package ftvp_pkg;

    localparam int TAG_OUT_BITS   = 20;
    localparam int LEN_OUT_BITS   = 16;
    localparam int GIVEN_BITS     = 10;
    localparam int GIVEN_MAX      = 1023;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 20;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = 2;
    localparam int FIFO_CNT_BITS  = 3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIMITER    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BEGIN_TAG    = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TYPE_TAG     = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECKSUM_TAG = 4'd3;

    typedef enum logic [1:0] {
        KIND_VALUE     = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_MSG_END   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_NO_BEGIN  = 3'd3,
        ST_NO_TYPE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_TAG     = 2'd1,
        PH_VALUE   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SG_NONE   = 2'd0,
        SG_DIGITS = 2'd1,
        SG_NEG    = 2'd2,
        SG_STOP   = 2'd3
    } sign_t;

    typedef enum logic [2:0] {
        TR_START  = 3'd0,
        TR_TAG    = 3'd1,
        TR_DIGITS = 3'd2,
        TR_DONE   = 3'd3,
        TR_FAIL   = 3'd4
    } trailer_t;

    typedef struct packed {
        logic [7:0]               delimiter;
        logic [CFG_DATA_BITS-1:0] begin_tag;
        logic [CFG_DATA_BITS-1:0] type_tag;
        logic [CFG_DATA_BITS-1:0] checksum_tag;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        delimiter:    8'd1,
        begin_tag:    20'd8,
        type_tag:     20'd35,
        checksum_tag: 20'd10
    };

    typedef struct packed {
        kind_t                   kind;
        logic [TAG_OUT_BITS-1:0] tag;
        logic [7:0]              value_byte;
        logic [LEN_OUT_BITS-1:0] value_length;
        status_t                 status;
        logic                    checksum_ok;
        logic [7:0]              checksum_computed;
        logic [GIVEN_BITS-1:0]   checksum_given;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic [1:0]    count;
        result_t [1:0] res;
    } step_t;

    typedef struct packed {
        phase_t                   phase;
        logic                     failed;
        sign_t                    sign;
        logic                     seen_begin;
        logic                     seen_type;
        logic                     byte_seen;
        logic [7:0]               running_sum;
        logic [7:0]               sum_last;
        logic [7:0]               sum_prev;
        logic [1:0]               delim_count;
        logic                     last_was_delim;
        trailer_t                 tmatch;
        logic [GIVEN_BITS-1:0]    tdigits;
        trailer_t                 prev_tmatch;
        logic [GIVEN_BITS-1:0]    prev_tdigits;
        logic [CFG_DATA_BITS-1:0] ttag;
    } msg_state_t;

    localparam msg_state_t MSG_CLEAR = '{
        phase:          PH_BETWEEN,
        failed:         1'b0,
        sign:           SG_NONE,
        seen_begin:     1'b0,
        seen_type:      1'b0,
        byte_seen:      1'b0,
        running_sum:    8'd0,
        sum_last:       8'd0,
        sum_prev:       8'd0,
        delim_count:    2'd0,
        last_was_delim: 1'b0,
        tmatch:         TR_START,
        tdigits:        10'd0,
        prev_tmatch:    TR_START,
        prev_tdigits:   10'd0,
        ttag:           20'd0
    };

endpackage

### design/fix_tag_value_parser_top.sv
// fix_tag_value_parser_top: FIX tag=value parser, config registers and result queue.
// A result is queued when its request is accepted and is offered from the queue head.
// Throughput: one request per cycle; an end request yields up to two results, drained one
// per cycle while out_ready is high from a four-entry queue; input stalls at three or more.
// Reset: config returns to defaults, message state and queue clear at once.
// Depends on ftvp_pkg and ftvp_parser.
module fix_tag_value_parser_top #(
    parameter int TAG_BITS    = 20,
    parameter int LENGTH_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic [7:0]                            data_byte,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ftvp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ftvp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            kind,
    output logic [ftvp_pkg::TAG_OUT_BITS-1:0]     tag,
    output logic [7:0]                            value_byte,
    output logic [ftvp_pkg::LEN_OUT_BITS-1:0]     value_length,
    output logic [2:0]                            status,
    output logic                                  checksum_ok,
    output logic [7:0]                            checksum_computed,
    output logic [ftvp_pkg::GIVEN_BITS-1:0]       checksum_given,
    output logic                                  last
);
    import ftvp_pkg::*;

    cfg_t                     cfg_reg;
    step_t                    step;
    logic                     accept, pop;
    result_t                  fifo_mem [FIFO_DEPTH];
    result_t                  head;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_inc;
    logic [FIFO_CNT_BITS-1:0] fill_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = fill_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
    assign accept    = in_valid && in_ready;
    assign out_valid = fill_reg != '0;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DELIMITER:    cfg_reg.delimiter    <= cfg_data[7:0];
                CFG_BEGIN_TAG:    cfg_reg.begin_tag    <= cfg_data;
                CFG_TYPE_TAG:     cfg_reg.type_tag     <= cfg_data;
                CFG_CHECKSUM_TAG: cfg_reg.checksum_tag <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ftvp_parser #(
        .TAG_BITS    (TAG_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .step      (step)
    );

    assign wr_ptr_inc = wr_ptr_reg + FIFO_PTR_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (step.count != 2'd0)
            fifo_mem[wr_ptr_reg] <= step.res[0];
        if (step.count == 2'd2)
            fifo_mem[wr_ptr_inc] <= step.res[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(step.count);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(pop);
            fill_reg   <= fill_reg + FIFO_CNT_BITS'(step.count) - FIFO_CNT_BITS'(pop);
        end
    end

    assign head              = fifo_mem[rd_ptr_reg];
    assign kind              = head.kind;
    assign tag               = head.tag;
    assign value_byte        = head.value_byte;
    assign value_length      = head.value_length;
    assign status            = head.status;
    assign checksum_ok       = head.checksum_ok;
    assign checksum_computed = head.checksum_computed;
    assign checksum_given    = head.checksum_given;
    assign last              = head.last;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_END)) |=> out_valid)
        else $error("end request produced no result");

    a_value_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_VALUE)) |-> last)
        else $error("value byte result not marked last");

    a_field_then_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (kind == KIND_FIELD_END) && !last) |=> (out_valid && (kind == KIND_MSG_END)))
        else $error("closing field end not followed by message end");

endmodule

### design/ftvp_parser.sv
// ftvp_parser: per-byte message state and result generation of the parser.
// One accepted request updates the state and yields up to two results.
// Depends on ftvp_pkg.
module ftvp_parser #(
    parameter int TAG_BITS    = 20,
    parameter int LENGTH_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            opcode,
    input  logic [7:0]      data_byte,
    input  ftvp_pkg::cfg_t  cfg,
    output ftvp_pkg::step_t step
);
    import ftvp_pkg::*;

    localparam int TAG_WIDE   = TAG_BITS + 4;
    localparam int TRAIL_WIDE = CFG_DATA_BITS + 4;
    localparam int DIG_WIDE   = GIVEN_BITS + 4;
    localparam int CMP_BITS   = (TAG_BITS > CFG_DATA_BITS) ? TAG_BITS : CFG_DATA_BITS;
    localparam logic [TAG_BITS-1:0]      TAG_MAX   = {TAG_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0]   LEN_MAX   = {LENGTH_BITS{1'b1}};
    localparam logic [CFG_DATA_BITS-1:0] TRAIL_MAX = {CFG_DATA_BITS{1'b1}};

    msg_state_t             st_reg, st_next;
    logic [TAG_BITS-1:0]    accum_reg, accum_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;

    logic                   is_delim, is_digit, is_space;
    logic [3:0]             digit;
    logic [TAG_WIDE-1:0]    tag_wide;
    logic [TAG_BITS-1:0]    tag_sat;
    logic [TRAIL_WIDE-1:0]  trail_wide;
    logic                   trail_over;
    logic [DIG_WIDE-1:0]    dig_wide;
    logic [GIVEN_BITS-1:0]  dig_sat;
    logic [7:0]             sum_new;

    logic                   close_ok, close_field, close_fail;
    logic                   accum_is_begin, accum_is_type;
    logic                   end_failed, end_begin, end_type;
    status_t                end_status;
    logic                   found, has_given;
    logic [7:0]             comp_sel, comp;
    trailer_t               tm_sel;
    logic [GIVEN_BITS-1:0]  td_sel, given;

    result_t                fe_res, msg_res, val_res;

    assign is_delim = (data_byte == cfg.delimiter);
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_space = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
    assign digit    = data_byte[3:0];

    assign tag_wide = TAG_WIDE'({accum_reg, 3'b000}) + TAG_WIDE'({accum_reg, 1'b0})
                    + TAG_WIDE'(digit);
    assign tag_sat  = (tag_wide > TAG_WIDE'(TAG_MAX)) ? TAG_MAX : tag_wide[TAG_BITS-1:0];

    assign trail_wide = TRAIL_WIDE'({st_reg.ttag, 3'b000}) + TRAIL_WIDE'({st_reg.ttag, 1'b0})
                      + TRAIL_WIDE'(digit);
    assign trail_over = trail_wide > TRAIL_WIDE'(TRAIL_MAX);

    assign dig_wide = DIG_WIDE'({st_reg.tdigits, 3'b000}) + DIG_WIDE'({st_reg.tdigits, 1'b0})
                    + DIG_WIDE'(digit);
    assign dig_sat  = (dig_wide > DIG_WIDE'(GIVEN_MAX)) ? GIVEN_BITS'(GIVEN_MAX)
                                                        : dig_wide[GIVEN_BITS-1:0];

    assign sum_new = st_reg.running_sum + data_byte;

    assign close_ok       = st_reg.byte_seen && !st_reg.failed;
    assign close_field    = close_ok && (st_reg.phase == PH_VALUE);
    assign close_fail     = close_ok && (st_reg.phase == PH_TAG);
    assign accum_is_begin = CMP_BITS'(accum_reg) == CMP_BITS'(cfg.begin_tag);
    assign accum_is_type  = CMP_BITS'(accum_reg) == CMP_BITS'(cfg.type_tag);
    assign end_failed     = st_reg.failed || close_fail;
    assign end_begin      = st_reg.seen_begin || (close_field && accum_is_begin);
    assign end_type       = st_reg.seen_type || (close_field && accum_is_type);

    always_comb
    begin
        if (!st_reg.byte_seen)
            end_status = ST_EMPTY;
        else if (end_failed)
            end_status = ST_MALFORMED;
        else if (!end_begin)
            end_status = ST_NO_BEGIN;
        else if (!end_type)
            end_status = ST_NO_TYPE;
        else
            end_status = ST_OK;
    end

    always_comb
    begin
        if (st_reg.last_was_delim)
        begin
            found    = st_reg.byte_seen && (st_reg.delim_count >= 2'd2);
            comp_sel = st_reg.sum_prev;
            tm_sel   = st_reg.prev_tmatch;
            td_sel   = st_reg.prev_tdigits;
        end
        else
        begin
            found    = st_reg.byte_seen && (st_reg.delim_count >= 2'd1);
            comp_sel = st_reg.sum_last;
            tm_sel   = st_reg.tmatch;
            td_sel   = st_reg.tdigits;
        end
    end

    assign has_given = found && ((tm_sel == TR_DIGITS) || (tm_sel == TR_DONE));
    assign comp      = found ? comp_sel : 8'd0;
    assign given     = has_given ? td_sel : '0;

    always_comb
    begin
        fe_res              = '0;
        fe_res.kind         = KIND_FIELD_END;
        fe_res.tag          = TAG_OUT_BITS'(accum_reg);
        fe_res.value_length = LEN_OUT_BITS'(count_reg);
        fe_res.last         = 1'b1;

        val_res             = '0;
        val_res.kind        = KIND_VALUE;
        val_res.tag         = TAG_OUT_BITS'(accum_reg);
        val_res.value_byte  = data_byte;
        val_res.last        = 1'b1;

        msg_res                   = '0;
        msg_res.kind              = KIND_MSG_END;
        msg_res.status            = end_status;
        msg_res.checksum_ok       = has_given && (GIVEN_BITS'(comp) == given);
        msg_res.checksum_computed = comp;
        msg_res.checksum_given    = given;
        msg_res.last              = 1'b1;
    end

    always_comb
    begin
        st_next    = st_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        step       = '0;

        if (accept && (opcode == OP_DATA))
        begin
            st_next.byte_seen      = 1'b1;
            st_next.running_sum    = sum_new;
            st_next.last_was_delim = is_delim;

            if (is_delim)
            begin
                st_next.prev_tmatch  = st_reg.tmatch;
                st_next.prev_tdigits = st_reg.tdigits;
                st_next.tmatch       = TR_START;
                st_next.tdigits      = '0;
                st_next.ttag         = '0;
                st_next.sum_prev     = st_reg.sum_last;
                st_next.sum_last     = sum_new;
                if (st_reg.delim_count != 2'd3)
                    st_next.delim_count = st_reg.delim_count + 2'd1;
            end
            else
            begin
                unique case (st_reg.tmatch)
                    TR_START:
                    begin
                        if ((data_byte >= CH_ONE) && (data_byte <= CH_NINE))
                        begin
                            st_next.ttag   = CFG_DATA_BITS'(digit);
                            st_next.tmatch = TR_TAG;
                        end
                        else
                            st_next.tmatch = TR_FAIL;
                    end
                    TR_TAG:
                    begin
                        if (is_digit)
                        begin
                            st_next.ttag = trail_wide[CFG_DATA_BITS-1:0];
                            if (trail_over)
                                st_next.tmatch = TR_FAIL;
                        end
                        else if (data_byte == CH_EQUAL)
                            st_next.tmatch = (st_reg.ttag == cfg.checksum_tag) ? TR_DIGITS
                                                                               : TR_FAIL;
                        else
                            st_next.tmatch = TR_FAIL;
                    end
                    TR_DIGITS:
                    begin
                        if (is_digit)
                            st_next.tdigits = dig_sat;
                        else
                            st_next.tmatch = TR_DONE;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (!st_reg.failed)
            begin
                if (is_delim)
                begin
                    if (st_reg.phase == PH_TAG)
                        st_next.failed = 1'b1;
                    else if (st_reg.phase == PH_VALUE)
                    begin
                        if (accum_is_begin)
                            st_next.seen_begin = 1'b1;
                        if (accum_is_type)
                            st_next.seen_type = 1'b1;
                        step.count     = 2'd1;
                        step.res[0]    = fe_res;
                        st_next.phase  = PH_BETWEEN;
                        st_next.sign   = SG_NONE;
                        accum_next     = '0;
                        count_next     = '0;
                    end
                end
                else if (st_reg.phase == PH_VALUE)
                begin
                    if (count_reg != LEN_MAX)
                        count_next = count_reg + LENGTH_BITS'(1);
                    step.count  = 2'd1;
                    step.res[0] = val_res;
                end
                else if (data_byte == CH_EQUAL)
                begin
                    if (accum_reg == '0)
                        st_next.failed = 1'b1;
                    else
                    begin
                        st_next.phase = PH_VALUE;
                        count_next    = '0;
                    end
                end
                else
                begin
                    st_next.phase = PH_TAG;
                    if ((st_reg.sign == SG_NONE) || (st_reg.sign == SG_DIGITS))
                    begin
                        if (is_digit)
                        begin
                            accum_next   = tag_sat;
                            st_next.sign = SG_DIGITS;
                        end
                        else if ((st_reg.sign == SG_NONE) && is_space)
                            st_next.sign = SG_NONE;
                        else if ((st_reg.sign == SG_NONE) && (data_byte == CH_PLUS))
                            st_next.sign = SG_DIGITS;
                        else if ((st_reg.sign == SG_NONE) && (data_byte == CH_MINUS))
                            st_next.sign = SG_NEG;
                        else
                            st_next.sign = SG_STOP;
                    end
                end
            end
        end
        else if (accept)
        begin
            if (close_field)
            begin
                step.count       = 2'd2;
                step.res[0]      = fe_res;
                step.res[0].last = 1'b0;
                step.res[1]      = msg_res;
            end
            else
            begin
                step.count  = 2'd1;
                step.res[0] = msg_res;
            end
            st_next    = MSG_CLEAR;
            accum_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= MSG_CLEAR;
            accum_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            accum_reg <= accum_next;
            count_reg <= count_next;
        end
    end

endmodule

### test/ftvp_result_checker.sv
// ftvp_result_checker: watches the parser's request, config and result channels,
// predicts every result from its own copy of the parser state and compares in order.
// Depends on ftvp_pkg.
module ftvp_result_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                opcode,
    input  logic [7:0]                          data_byte,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ftvp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ftvp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [1:0]                          kind,
    input  logic [ftvp_pkg::TAG_OUT_BITS-1:0]   tag,
    input  logic [7:0]                          value_byte,
    input  logic [ftvp_pkg::LEN_OUT_BITS-1:0]   value_length,
    input  logic [2:0]                          status,
    input  logic                                checksum_ok,
    input  logic [7:0]                          checksum_computed,
    input  logic [ftvp_pkg::GIVEN_BITS-1:0]     checksum_given,
    input  logic                                last,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ftvp_pkg::*;

    localparam logic [TAG_OUT_BITS-1:0] TAG_LIMIT    = '1;
    localparam logic [LEN_OUT_BITS-1:0] LEN_LIMIT    = '1;

    cfg_t                    regs;
    phase_t                  field_phase;
    logic                    msg_failed;
    logic [TAG_OUT_BITS-1:0] tag_acc;
    sign_t                   tag_sign;
    logic [LEN_OUT_BITS-1:0] tag_len;
    logic [LEN_OUT_BITS-1:0] value_cnt;
    logic                    saw_begin;
    logic                    saw_type;
    logic                    saw_byte;
    logic [7:0]              byte_sum;
    logic [7:0]              sum_at_delim;
    logic [7:0]              sum_before_delim;
    logic [1:0]              delim_seen;
    logic                    ended_on_delim;
    trailer_t                trl_state;
    trailer_t                trl_state_prev;
    logic [GIVEN_BITS-1:0]   trl_digits;
    logic [GIVEN_BITS-1:0]   trl_digits_prev;
    logic [31:0]             trl_tag;

    result_t expected_results[$];
    int      mismatches;

    task automatic clear_message();
        field_phase     = PH_BETWEEN;
        msg_failed      = 1'b0;
        tag_acc         = '0;
        tag_sign        = SG_NONE;
        tag_len         = '0;
        value_cnt       = '0;
        saw_begin       = 1'b0;
        saw_type        = 1'b0;
        saw_byte        = 1'b0;
        byte_sum        = '0;
        sum_at_delim    = '0;
        sum_before_delim = '0;
        delim_seen      = '0;
        ended_on_delim  = 1'b0;
        trl_state       = TR_START;
        trl_state_prev  = TR_START;
        trl_digits      = '0;
        trl_digits_prev = '0;
        trl_tag         = '0;
    endtask

    function automatic result_t make_result(kind_t k, logic [TAG_OUT_BITS-1:0] t,
                                            logic [7:0] vb, logic [LEN_OUT_BITS-1:0] len,
                                            status_t st, logic ok, logic [7:0] comp,
                                            logic [GIVEN_BITS-1:0] given, logic closes);
        result_t r;
        r.kind              = k;
        r.tag               = t;
        r.value_byte        = vb;
        r.value_length      = len;
        r.status            = st;
        r.checksum_ok       = ok;
        r.checksum_computed = comp;
        r.checksum_given    = given;
        r.last              = closes;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    task automatic advance_trailer(input logic [7:0] b);
        logic [31:0] d;
        logic [31:0] acc;
        d = {24'd0, b} - {24'd0, CH_ZERO};
        case (trl_state)
            TR_START:
            begin
                if (b >= CH_ONE && b <= CH_NINE)
                begin
                    trl_tag   = d;
                    trl_state = TR_TAG;
                end
                else
                    trl_state = TR_FAIL;
            end
            TR_TAG:
            begin
                if (is_digit(b))
                begin
                    trl_tag = trl_tag * 10 + d;
                    if (trl_tag > 32'hFFFFF)
                        trl_state = TR_FAIL;
                end
                else if (b == CH_EQUAL)
                    trl_state = (trl_tag == {12'd0, regs.checksum_tag}) ? TR_DIGITS : TR_FAIL;
                else
                    trl_state = TR_FAIL;
            end
            TR_DIGITS:
            begin
                if (is_digit(b))
                begin
                    acc        = {22'd0, trl_digits} * 10 + d;
                    trl_digits = (acc > GIVEN_MAX) ? GIVEN_BITS'(GIVEN_MAX) : acc[GIVEN_BITS-1:0];
                end
                else
                    trl_state = TR_DONE;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic advance_tag(input logic [7:0] b);
        logic        blank;
        logic [31:0] acc;
        blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        if (tag_len != LEN_LIMIT)
            tag_len = tag_len + 1'b1;
        if (tag_sign == SG_NONE || tag_sign == SG_DIGITS)
        begin
            if (is_digit(b))
            begin
                acc      = {12'd0, tag_acc} * 10 + {24'd0, b} - {24'd0, CH_ZERO};
                tag_acc  = (acc > {12'd0, TAG_LIMIT}) ? TAG_LIMIT : acc[TAG_OUT_BITS-1:0];
                tag_sign = SG_DIGITS;
            end
            else if (tag_sign == SG_NONE && blank)
            begin
            end
            else if (tag_sign == SG_NONE && b == CH_PLUS)
                tag_sign = SG_DIGITS;
            else if (tag_sign == SG_NONE && b == CH_MINUS)
                tag_sign = SG_NEG;
            else
                tag_sign = SG_STOP;
        end
    endtask

    task automatic close_field(input logic closes);
        if (field_phase == PH_TAG)
            msg_failed = 1'b1;
        else if (field_phase == PH_VALUE)
        begin
            if (tag_acc == regs.begin_tag)
                saw_begin = 1'b1;
            if (tag_acc == regs.type_tag)
                saw_type = 1'b1;
            expected_results.push_back(make_result(KIND_FIELD_END, tag_acc, 8'd0, value_cnt,
                                                   ST_OK, 1'b0, 8'd0, '0, closes));
            field_phase = PH_BETWEEN;
            tag_acc     = '0;
            tag_sign    = SG_NONE;
            tag_len     = '0;
            value_cnt   = '0;
        end
    endtask

    task automatic predict_request(input logic op, input logic [7:0] b);
        logic                  at_delim;
        logic                  found;
        logic [7:0]            comp;
        trailer_t              tm;
        logic [GIVEN_BITS-1:0] td;
        logic [GIVEN_BITS-1:0] given;
        logic                  ok;
        status_t               st;
        if (op == OP_DATA)
        begin
            at_delim = (b == regs.delimiter);
            saw_byte = 1'b1;
            byte_sum = byte_sum + b;
            if (at_delim)
            begin
                trl_state_prev   = trl_state;
                trl_digits_prev  = trl_digits;
                trl_state        = TR_START;
                trl_digits       = '0;
                trl_tag          = '0;
                sum_before_delim = sum_at_delim;
                sum_at_delim     = byte_sum;
                if (delim_seen != 2'd3)
                    delim_seen = delim_seen + 1'b1;
            end
            else
                advance_trailer(b);
            ended_on_delim = at_delim;

            if (!msg_failed)
            begin
                if (at_delim)
                    close_field(1'b1);
                else if (field_phase == PH_VALUE)
                begin
                    if (value_cnt != LEN_LIMIT)
                        value_cnt = value_cnt + 1'b1;
                    expected_results.push_back(make_result(KIND_VALUE, tag_acc, b, '0, ST_OK,
                                                           1'b0, 8'd0, '0, 1'b1));
                end
                else if (b == CH_EQUAL)
                begin
                    if (tag_len == 0 || tag_sign == SG_NEG || tag_acc == 0)
                        msg_failed = 1'b1;
                    else
                    begin
                        field_phase = PH_VALUE;
                        value_cnt   = '0;
                    end
                end
                else
                begin
                    field_phase = PH_TAG;
                    advance_tag(b);
                end
            end
        end
        else
        begin
            if (saw_byte && !msg_failed)
                close_field(1'b0);

            if (!saw_byte)
                st = ST_EMPTY;
            else if (msg_failed)
                st = ST_MALFORMED;
            else if (!saw_begin)
                st = ST_NO_BEGIN;
            else if (!saw_type)
                st = ST_NO_TYPE;
            else
                st = ST_OK;

            if (ended_on_delim)
            begin
                found = delim_seen >= 2;
                comp  = sum_before_delim;
                tm    = trl_state_prev;
                td    = trl_digits_prev;
            end
            else
            begin
                found = delim_seen >= 1;
                comp  = sum_at_delim;
                tm    = trl_state;
                td    = trl_digits;
            end
            if (!saw_byte)
                found = 1'b0;
            if (!found)
                comp = '0;
            given = '0;
            ok    = 1'b0;
            if (found && (tm == TR_DIGITS || tm == TR_DONE))
            begin
                given = td;
                ok    = ({2'b00, comp} == given);
            end
            expected_results.push_back(make_result(KIND_MSG_END, '0, 8'd0, '0, st, ok, comp,
                                                   given, 1'b1));
            clear_message();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: result mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_result();
        result_t want;
        want = expected_results.pop_front();
        if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (tag !== want.tag)
            report_mismatch($sformatf("tag %0d, want %0d", tag, want.tag));
        if (value_byte !== want.value_byte)
            report_mismatch($sformatf("value_byte %0d, want %0d", value_byte, want.value_byte));
        if (value_length !== want.value_length)
            report_mismatch($sformatf("value_length %0d, want %0d", value_length,
                                      want.value_length));
        if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (checksum_ok !== want.checksum_ok)
            report_mismatch($sformatf("checksum_ok %0d, want %0d", checksum_ok,
                                      want.checksum_ok));
        if (checksum_computed !== want.checksum_computed)
            report_mismatch($sformatf("checksum_computed %0d, want %0d", checksum_computed,
                                      want.checksum_computed));
        if (checksum_given !== want.checksum_given)
            report_mismatch($sformatf("checksum_given %0d, want %0d", checksum_given,
                                      want.checksum_given));
        if (last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = CFG_RESET;
            clear_message();
            expected_results.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DELIMITER:    regs.delimiter    = cfg_data[7:0];
                    CFG_BEGIN_TAG:    regs.begin_tag    = cfg_data;
                    CFG_TYPE_TAG:     regs.type_tag     = cfg_data;
                    CFG_CHECKSUM_TAG: regs.checksum_tag = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                predict_request(opcode, data_byte);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("kind %0d tag %0d arrived with nothing pending",
                                              kind, tag));
                else
                    compare_result();
            end
            pending    <= expected_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

### test/fix_tag_value_parser_top_tb.sv
// fix_tag_value_parser_top_tb: drives FIX byte streams and config writes into the parser
// under random idling on both channels and gives the verdict from the result checker.
// Depends on ftvp_pkg, fix_tag_value_parser_top and ftvp_result_checker.
module fix_tag_value_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ftvp_pkg::*;

    localparam int                        CYCLE_LIMIT = 2_000_000;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED  = 4'hF;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_SUM,
        SHAPE_NO_EQUAL,
        SHAPE_ZERO_TAG,
        SHAPE_NEG_TAG,
        SHAPE_EMPTY_TAG,
        SHAPE_HUGE_TAG,
        SHAPE_NO_BEGIN,
        SHAPE_NO_TYPE,
        SHAPE_ODD_TRAILER,
        SHAPE_NOISE,
        SHAPE_DELIMS
    } msg_shape_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      opcode    = OP_DATA;
    logic [7:0]                data_byte = 8'd0;
    logic                      cfg_valid = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_DELIMITER;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      out_ready = 1'b0;

    logic                      in_ready;
    logic                      cfg_ready;
    logic                      out_valid;
    logic [1:0]                kind;
    logic [TAG_OUT_BITS-1:0]   tag;
    logic [7:0]                value_byte;
    logic [LEN_OUT_BITS-1:0]   value_length;
    logic [2:0]                status;
    logic                      checksum_ok;
    logic [7:0]                checksum_computed;
    logic [GIVEN_BITS-1:0]     checksum_given;
    logic                      last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int hold_cycles = 0;
    int items_sent  = 0;
    bit quiet       = 1'b0;

    logic [7:0]               sep       = 8'd1;
    logic [CFG_DATA_BITS-1:0] begin_num = 20'd8;
    logic [CFG_DATA_BITS-1:0] type_num  = 20'd35;
    logic [CFG_DATA_BITS-1:0] cksum_num = 20'd10;
    logic [7:0]               msg_bytes[$];

    fix_tag_value_parser_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .data_byte        (data_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .tag              (tag),
        .value_byte       (value_byte),
        .value_length     (value_length),
        .status           (status),
        .checksum_ok      (checksum_ok),
        .checksum_computed(checksum_computed),
        .checksum_given   (checksum_given),
        .last             (last)
    );

    ftvp_result_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .data_byte        (data_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .tag              (tag),
        .value_byte       (value_byte),
        .value_length     (value_length),
        .status           (status),
        .checksum_ok      (checksum_ok),
        .checksum_computed(checksum_computed),
        .checksum_given   (checksum_given),
        .last             (last),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (quiet || $urandom_range(0, 99) < 75)
            out_ready <= 1'b1;
        else
        begin
            out_ready   <= 1'b0;
            hold_cycles <= stall_len() - 1;
        end
    end

    function automatic logic [7:0] any_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == sep)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        logic [7:0] b;
        b = CH_SPACE;
        do
            b = ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
        while (b == sep);
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 8'(CH_ZERO + $urandom_range(0, 9));
        if (r < 45)
            return CH_EQUAL;
        if (r < 60)
            return sep;
        if (r < 70)
            return ($urandom_range(0, 1) != 0) ? CH_MINUS : blank_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_text(input string s);
        foreach (s[i])
            msg_bytes.push_back(s[i]);
    endtask

    task automatic put_tag(input int num, input bit fancy);
        if (fancy)
        begin
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 2)) msg_bytes.push_back(blank_byte());
                1: msg_bytes.push_back(CH_PLUS);
                2: put_text("00");
                default:
                begin
                end
            endcase
        end
        put_text($sformatf("%0d", num));
        if (fancy && $urandom_range(0, 4) == 0)
            put_text("x");
    endtask

    task automatic put_field(input int num, input int vlen);
        put_tag(num, $urandom_range(0, 4) == 0);
        msg_bytes.push_back(CH_EQUAL);
        repeat (vlen) msg_bytes.push_back(any_byte());
        msg_bytes.push_back(sep);
    endtask

    task automatic build_message(input msg_shape_t shape);
        int sum;
        msg_bytes.delete();
        if (shape == SHAPE_NOISE)
        begin
            repeat ($urandom_range(1, 24)) msg_bytes.push_back(noise_byte());
            return;
        end
        if (shape == SHAPE_DELIMS)
        begin
            repeat ($urandom_range(0, 3)) msg_bytes.push_back(sep);
            return;
        end

        if (shape != SHAPE_NO_BEGIN)
            put_field(begin_num, $urandom_range(1, 7));
        put_field(9, $urandom_range(1, 3));
        if (shape != SHAPE_NO_TYPE)
            put_field(type_num, $urandom_range(1, 2));
        case (shape)
            SHAPE_NO_EQUAL:  put_text($sformatf("%0d", $urandom_range(1, 999)));
            SHAPE_ZERO_TAG:  put_text("00=q");
            SHAPE_NEG_TAG:   put_text("-7=ab");
            SHAPE_EMPTY_TAG: put_text("=ab");
            SHAPE_HUGE_TAG:  put_text("99999999=z");
            default:
            begin
            end
        endcase
        if (shape inside {SHAPE_NO_EQUAL, SHAPE_ZERO_TAG, SHAPE_NEG_TAG, SHAPE_EMPTY_TAG,
                          SHAPE_HUGE_TAG})
            msg_bytes.push_back(sep);
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 7) == 0)
                msg_bytes.push_back(sep);
            put_field($urandom_range(1, 9999), $urandom_range(0, 6));
        end

        sum = 0;
        foreach (msg_bytes[i])
            sum = (sum + msg_bytes[i]) % 256;
        if (shape == SHAPE_BAD_SUM)
            sum = (sum + 1) % 256;
        if (shape == SHAPE_ODD_TRAILER)
        begin
            case ($urandom_range(0, 5))
                0: put_text($sformatf("0%0d=%03d", cksum_num, sum));
                1: put_text($sformatf("%0d=12345", cksum_num));
                2: put_text($sformatf("%0d=%0dx7", cksum_num, sum));
                3: put_text("99999999=0");
                4: put_text($sformatf("%0d=", cksum_num));
                default:
                begin
                end
            endcase
        end
        else
            put_text($sformatf("%0d=%03d", cksum_num, sum));
        if ($urandom_range(0, 3) != 0)
            msg_bytes.push_back(sep);
    endtask

    task automatic send_req(input logic op, input logic [7:0] b);
        int gap;
        gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : stall_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_message();
        foreach (msg_bytes[i])
            send_req(OP_DATA, msg_bytes[i]);
        send_req(OP_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_setting(input logic [7:0] d, input logic [CFG_DATA_BITS-1:0] bt,
                                 input logic [CFG_DATA_BITS-1:0] tt,
                                 input logic [CFG_DATA_BITS-1:0] ct, input bit poke_unused);
        settle();
        if (poke_unused)
            write_reg(CFG_UNUSED, 20'hFFFFF);
        // upper bits of the delimiter write must be dropped
        write_reg(CFG_DELIMITER, {12'hFA5, d});
        write_reg(CFG_BEGIN_TAG, bt);
        write_reg(CFG_TYPE_TAG, tt);
        write_reg(CFG_CHECKSUM_TAG, ct);
        cfg_valid <= 1'b0;
        sep       = d;
        begin_num = bt;
        type_num  = tt;
        cksum_num = ct;
    endtask

    task automatic run_random(input int quota);
        int         start;
        msg_shape_t shape;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            quiet = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 99) < 55)
                shape = SHAPE_GOOD;
            else
                shape = msg_shape_t'($urandom_range(SHAPE_BAD_SUM, SHAPE_DELIMS));
            build_message(shape);
            send_message();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        msg_bytes.delete();
        send_message();
        put_text("8=");
        msg_bytes.push_back(8'hFF);
        msg_bytes.push_back(sep);
        put_text("35=");
        msg_bytes.push_back(8'h00);
        send_message();
        msg_bytes.delete();
        put_text("-1=x");
        send_message();
        msg_bytes.delete();
        put_text("9");
        msg_bytes.push_back(sep);
        send_message();
        msg_bytes.delete();
        put_text("=");
        msg_bytes.push_back(sep);
        send_message();

        run_random(300);
        apply_setting(8'h7C, 20'd1, 20'hFFFFF, 20'd1, 1'b0);
        run_random(250);
        apply_setting(8'h00, 20'hFFFFF, 20'd1, 20'hFFFFF, 1'b0);
        run_random(250);
        apply_setting(8'hFF, 20'd49, 20'd52, 20'd999, 1'b0);
        run_random(250);
        apply_setting(8'h0A, 20'd8, 20'd35, 20'd10, 1'b0);
        run_random(150);
        apply_setting(8'h01, 20'd8, 20'd35, 20'd10, 1'b1);
        run_random(150);

        settle();
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### fix_tag_value_parser_top.f
design/ftvp_pkg.sv
design/ftvp_parser.sv
design/fix_tag_value_parser_top.sv
test/ftvp_result_checker.sv
test/fix_tag_value_parser_top_tb.sv
